@@ rtl/spcu_pkg.sv @@
// Shared constants, types and a fixed-point helper of the clause update block.
package spcu_pkg;

  localparam int FRAC_BITS = 31;
  localparam int VAL_W     = 32;
  localparam int CNT16_W   = 16;
  localparam int DEN_W     = VAL_W + 1;
  localparam int MAX_LITS_DEFAULT = 16;

  localparam logic [VAL_W-1:0] ONE = VAL_W'(64'd1 << FRAC_BITS);

  localparam logic [1:0] REG_ONE_MINUS_RHO  = 2'd0;
  localparam logic [1:0] REG_ZERO_THRESHOLD = 2'd1;

  typedef struct packed {
    logic [VAL_W-1:0]   cf;
    logic               neg;
    logic               act;
    logic [CNT16_W-1:0] nz;
    logic [CNT16_W-1:0] pz;
    logic [VAL_W-1:0]   np;
    logic [VAL_W-1:0]   pp;
    logic [VAL_W-1:0]   eta;
  } spcu_entry_t;

  // Saturate a value at ONE.
  function automatic logic [VAL_W-1:0] clamp1(input logic [VAL_W:0] x);
    clamp1 = (x > {1'b0, ONE}) ? ONE : x[VAL_W-1:0];
  endfunction

endpackage

@@ rtl/survey_prop_clause_update.sv @@
// Top level of the survey propagation clause update block.
//
// Usage: present one literal of a clause per transaction on the input ports
// with start high; a transaction is taken at a rising edge with start high
// and busy low. The literal marked last_literal closes the clause.
// Configuration (damping one_minus_rho, zero_threshold) is written through
// cfg_valid/cfg_ready/cfg_index/cfg_data; the user must write it only while
// the block is idle, which the block does not enforce; cfg_ready is always high.
// An inactive literal holds busy only through the buffer write; an active
// literal holds it longer: its cavity factor needs up to two passes through the
// shared bit-serial divider plus steps on the shared 32x32 multiplier. After the
// last literal, results follow in arrival order, one per literal, each needing
// up to two divider passes and one multiply. Each result is shown for one cycle
// with result_strobe high; the receiver must take it then, as it cannot stall.
// The final result carries last_result and max_change.
// Reset (rst, synchronous) empties the clause, restores full product to ONE,
// one_minus_rho to ONE and zero_threshold to 0.
module survey_prop_clause_update
  import spcu_pkg::*;
#(
  parameter int MAX_LITS = MAX_LITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [VAL_W-1:0]    literal_eta,
  input  logic [VAL_W-1:0]    var_pos_product,
  input  logic [VAL_W-1:0]    var_neg_product,
  input  logic [CNT16_W-1:0]  var_pos_zeros,
  input  logic [CNT16_W-1:0]  var_neg_zeros,
  input  logic                negated,
  input  logic                active,
  input  logic                last_literal,
  output logic                result_strobe,
  output logic [VAL_W-1:0]    new_eta,
  output logic [VAL_W-1:0]    new_pos_product,
  output logic [VAL_W-1:0]    new_neg_product,
  output logic [CNT16_W-1:0]  new_pos_zeros,
  output logic [CNT16_W-1:0]  new_neg_zeros,
  output logic [VAL_W-1:0]    max_change,
  output logic                last_result,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [VAL_W-1:0]    cfg_data
);

  localparam int ADDR_W = $clog2(MAX_LITS);
  localparam int CNT_W  = $clog2(MAX_LITS + 1);
  localparam int ENT_W  = $bits(spcu_entry_t);

  // Sequencer codes
  localparam logic [4:0] S_IDLE  = 5'd0;
  localparam logic [4:0] S_CN    = 5'd1;
  localparam logic [4:0] S_CNW   = 5'd2;
  localparam logic [4:0] S_M1    = 5'd3;
  localparam logic [4:0] S_WN    = 5'd4;
  localparam logic [4:0] S_CFS   = 5'd5;
  localparam logic [4:0] S_CFW   = 5'd6;
  localparam logic [4:0] S_FULL  = 5'd7;
  localparam logic [4:0] S_WR    = 5'd8;
  localparam logic [4:0] S_RD    = 5'd9;
  localparam logic [4:0] S_LD    = 5'd10;
  localparam logic [4:0] S_NEW   = 5'd11;
  localparam logic [4:0] S_SIDE  = 5'd12;
  localparam logic [4:0] S_SDIVS = 5'd13;
  localparam logic [4:0] S_SDIVW = 5'd14;
  localparam logic [4:0] S_OUT   = 5'd15;

  logic [4:0]         state;
  logic [VAL_W-1:0]   one_minus_rho;
  logic [CNT16_W-1:0] zero_threshold;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [1:0]         vcount;
  logic [VAL_W-1:0]   full;
  logic [VAL_W-1:0]   maxc;

  // Working registers
  spcu_entry_t        ent;
  logic               last_r;
  logic [VAL_W-1:0]   eta;
  logic [VAL_W-1:0]   own;
  logic [CNT16_W-1:0] own_z;
  logic [VAL_W-1:0]   t;
  logic [VAL_W-1:0]   n;
  logic [VAL_W-1:0]   wn;
  logic [VAL_W-1:0]   tmp;
  logic [VAL_W-1:0]   cf;
  logic [VAL_W-1:0]   ne;
  logic [VAL_W-1:0]   pp;
  logic [VAL_W-1:0]   np;
  logic [CNT16_W-1:0] pz;
  logic [CNT16_W-1:0] nz;

  logic [VAL_W-1:0]   thr;
  logic [VAL_W-1:0]   one_m_eta;
  logic [VAL_W-1:0]   one_m_ne;
  logic [VAL_W-1:0]   side_prod;
  logic               eta_live;
  logic               ne_live;

  // Shared multiplier
  logic [VAL_W-1:0]   mul_a;
  logic [VAL_W-1:0]   mul_b;
  logic [2*VAL_W-1:0] mul_p;
  logic [VAL_W-1:0]   mul_q;

  // Shared divider
  logic               div_start;
  logic [VAL_W-1:0]   div_num;
  logic [DEN_W-1:0]   div_den;
  logic               div_done;
  logic [VAL_W-1:0]   div_q;

  spcu_entry_t        rd_ent;
  logic [ENT_W-1:0]   rd_word;
  logic               accept;
  logic               is_last_out;
  logic [VAL_W-1:0]   diff;

  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  assign thr       = {{(VAL_W-CNT16_W){1'b0}}, zero_threshold};
  assign one_m_eta = ONE - eta;
  assign one_m_ne  = ONE - ne;
  assign eta_live  = one_m_eta > thr;
  assign ne_live   = one_m_ne > thr;
  assign side_prod = ent.neg ? pp : np;
  assign rd_ent    = spcu_entry_t'(rd_word);
  assign is_last_out = (idx == count - 1'b1);
  assign diff      = (eta > ne) ? eta - ne : ne - eta;

  // Pick multiplier operands for the step in hand.
  always_comb begin
    case (state)
      S_M1: begin
        mul_a = t;
        mul_b = one_minus_rho;
      end
      S_WN: begin
        mul_a = n;
        mul_b = ONE - tmp;
      end
      S_FULL: begin
        mul_a = full;
        mul_b = cf;
      end
      default: begin
        mul_a = side_prod;
        mul_b = one_m_ne;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;
  assign mul_q = clamp1(mul_p[FRAC_BITS +: VAL_W+1]);

  // Pick divider operands and kick it off.
  always_comb begin
    div_start = 1'b0;
    div_num   = side_prod;
    div_den   = {1'b0, one_m_eta};
    case (state)
      S_CN: begin
        div_start = (own_z == '0);
        div_num   = own;
      end
      S_CFS: begin
        div_start = 1'b1;
        div_num   = wn;
        div_den   = {1'b0, wn} + {1'b0, t};
      end
      S_LD: begin
        div_start = rd_ent.act && (vcount == 2'd0);
        div_num   = full;
        div_den   = {1'b0, rd_ent.cf};
      end
      S_SIDE: begin
        div_start = eta_live && !ne_live;
      end
      S_SDIVS: begin
        div_start = 1'b1;
        div_num   = tmp;
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  spcu_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_q)
  );

  spcu_ram #(
    .WIDTH (ENT_W),
    .DEPTH (MAX_LITS)
  ) u_buf (
    .clk   (clk),
    .we    (state == S_WR),
    .waddr (count[ADDR_W-1:0]),
    .wdata (ENT_W'({cf, ent.neg, ent.act, ent.nz, ent.pz, ent.np, ent.pp, ent.eta})),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (rd_word)
  );

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      one_minus_rho  <= ONE;
      zero_threshold <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ONE_MINUS_RHO:  one_minus_rho  <= cfg_data;
        REG_ZERO_THRESHOLD: zero_threshold <= cfg_data[CNT16_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      idx           <= '0;
      vcount        <= '0;
      full          <= ONE;
      maxc          <= '0;
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= last_literal;
            if (count >= CNT_W'(MAX_LITS)) begin
              // Drop overflow literals; a dropped last still closes the clause.
              if (last_literal) begin
                idx   <= '0;
                state <= S_RD;
              end
            end else begin
              ent.eta <= literal_eta;
              ent.pp  <= var_pos_product;
              ent.np  <= var_neg_product;
              ent.pz  <= var_pos_zeros;
              ent.nz  <= var_neg_zeros;
              ent.neg <= negated;
              ent.act <= active;
              cf      <= '0;
              eta     <= clamp1({1'b0, literal_eta});
              own     <= negated ? clamp1({1'b0, var_pos_product})
                                 : clamp1({1'b0, var_neg_product});
              own_z   <= negated ? var_pos_zeros : var_neg_zeros;
              if ((negated ? var_neg_zeros : var_pos_zeros) != '0) begin
                t <= '0;
              end else begin
                t <= negated ? clamp1({1'b0, var_neg_product})
                             : clamp1({1'b0, var_pos_product});
              end
              state <= active ? S_CN : S_WR;
            end
          end
        end
        S_CN: begin
          if (own_z == '0) begin
            state <= S_CNW;
          end else begin
            n     <= (own_z == CNT16_W'(1) && !eta_live) ? own : '0;
            state <= S_M1;
          end
        end
        S_CNW: begin
          if (div_done) begin
            n     <= div_q;
            state <= S_M1;
          end
        end
        S_M1: begin
          tmp   <= mul_q;
          state <= S_WN;
        end
        S_WN: begin
          wn    <= mul_q;
          state <= S_CFS;
        end
        S_CFS: begin
          state <= S_CFW;
        end
        S_CFW: begin
          if (div_done) begin
            cf    <= div_q;
            state <= S_FULL;
          end
        end
        S_FULL: begin
          if (cf <= thr) begin
            if (vcount != 2'd2) begin
              vcount <= vcount + 1'b1;
            end
          end else begin
            full <= mul_q;
          end
          state <= S_WR;
        end
        S_WR: begin
          count <= count + 1'b1;
          if (last_r) begin
            idx   <= '0;
            state <= S_RD;
          end else begin
            state <= S_IDLE;
          end
        end
        S_RD: begin
          // Read address is idx; data lands next cycle.
          state <= S_LD;
        end
        S_LD: begin
          ent <= rd_ent;
          pz  <= rd_ent.pz;
          nz  <= rd_ent.nz;
          if (rd_ent.act) begin
            eta <= clamp1({1'b0, rd_ent.eta});
            pp  <= clamp1({1'b0, rd_ent.pp});
            np  <= clamp1({1'b0, rd_ent.np});
            if (vcount == 2'd0) begin
              state <= S_NEW;
            end else begin
              ne    <= (vcount == 2'd1 && rd_ent.cf <= thr) ? full : '0;
              state <= S_SIDE;
            end
          end else begin
            eta   <= rd_ent.eta;
            pp    <= rd_ent.pp;
            np    <= rd_ent.np;
            state <= S_OUT;
          end
        end
        S_NEW: begin
          if (div_done) begin
            ne    <= div_q;
            state <= S_SIDE;
          end
        end
        S_SIDE: begin
          if (eta_live && ne_live) begin
            tmp   <= mul_q;
            state <= S_SDIVS;
          end else if (eta_live) begin
            if (ent.neg) begin
              if (pz != '1) pz <= pz + 1'b1;
            end else begin
              if (nz != '1) nz <= nz + 1'b1;
            end
            state <= S_SDIVW;
          end else if (ne_live) begin
            if (ent.neg) begin
              pp <= mul_q;
              if (pz != '0) pz <= pz - 1'b1;
            end else begin
              np <= mul_q;
              if (nz != '0) nz <= nz - 1'b1;
            end
            state <= S_OUT;
          end else begin
            state <= S_OUT;
          end
        end
        S_SDIVS: begin
          state <= S_SDIVW;
        end
        S_SDIVW: begin
          if (div_done) begin
            if (ent.neg) begin
              pp <= div_q;
            end else begin
              np <= div_q;
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          result_strobe   <= 1'b1;
          new_eta         <= ent.act ? ne : eta;
          new_pos_product <= pp;
          new_neg_product <= np;
          new_pos_zeros   <= pz;
          new_neg_zeros   <= nz;
          last_result     <= is_last_out;
          if (is_last_out) begin
            max_change <= (ent.act && diff > maxc) ? diff : maxc;
            count      <= '0;
            vcount     <= '0;
            full       <= ONE;
            maxc       <= '0;
            state      <= S_IDLE;
          end else begin
            max_change <= '0;
            if (ent.act && diff > maxc) begin
              maxc <= diff;
            end
            idx   <= idx + 1'b1;
            state <= S_RD;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/spcu_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module spcu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/spcu_div.sv @@
// Restoring fixed-point divider, one quotient bit per cycle, saturating at ONE.
module spcu_div
  import spcu_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [VAL_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  output logic             done,
  output logic [VAL_W-1:0] quo
);

  localparam int STEP_W = $clog2(FRAC_BITS + 1);

  logic              run;
  logic [STEP_W-1:0] step;
  logic [DEN_W:0]    rem;
  logic [DEN_W:0]    rem_shift;
  logic [DEN_W-1:0]  den_r;

  assign rem_shift = {rem[DEN_W-1:0], 1'b0};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        den_r <= den;
        step  <= '0;
        if (den == '0) begin
          quo  <= '0;
          done <= 1'b1;
        end else if ({1'b0, num} >= den) begin
          quo  <= ONE;
          done <= 1'b1;
        end else begin
          rem <= {2'b00, num};
          quo <= '0;
          run <= 1'b1;
        end
      end else if (run) begin
        if (rem_shift >= {1'b0, den_r}) begin
          rem <= rem_shift - {1'b0, den_r};
          quo <= {quo[VAL_W-2:0], 1'b1};
        end else begin
          rem <= rem_shift;
          quo <= {quo[VAL_W-2:0], 1'b0};
        end
        step <= step + 1'b1;
        if (step == STEP_W'(FRAC_BITS - 1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule
